@@ hdl/csl_pkg.sv @@
package csl_pkg;

   // lexer mode between bytes
   typedef enum logic [2:0] {
      MODE_START,
      MODE_WORD,
      MODE_NUM,
      MODE_LT,
      MODE_GT,
      MODE_EQ,
      MODE_BANG,
      MODE_DROP
   } mode_type;

   // token kinds
   localparam logic [3:0] KIND_OP     = 4'd0;
   localparam logic [3:0] KIND_NUM    = 4'd1;
   localparam logic [3:0] KIND_IDENT  = 4'd2;
   localparam logic [3:0] KIND_RETURN = 4'd3;
   localparam logic [3:0] KIND_IF     = 4'd4;
   localparam logic [3:0] KIND_ELSE   = 4'd5;
   localparam logic [3:0] KIND_WHILE  = 4'd6;
   localparam logic [3:0] KIND_FOR    = 4'd7;
   localparam logic [3:0] KIND_EOF    = 4'd8;
   localparam logic [3:0] KIND_ERROR  = 4'd9;

   // operator codes
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_PLUS   = 5'd0;
   localparam logic [4:0] OP_MINUS  = 5'd1;
   localparam logic [4:0] OP_STAR   = 5'd2;
   localparam logic [4:0] OP_SLASH  = 5'd3;
   localparam logic [4:0] OP_LPAREN = 5'd4;
   localparam logic [4:0] OP_RPAREN = 5'd5;
   localparam logic [4:0] OP_SEMI   = 5'd6;
   localparam logic [4:0] OP_ASSIGN = 5'd7;
   localparam logic [4:0] OP_LBRACE = 5'd8;
   localparam logic [4:0] OP_RBRACE = 5'd9;
   localparam logic [4:0] OP_COMMA  = 5'd10;
   localparam logic [4:0] OP_EQ     = 5'd11;
   localparam logic [4:0] OP_NE     = 5'd12;
   localparam logic [4:0] OP_LT     = 5'd13;
   localparam logic [4:0] OP_LE     = 5'd14;
   localparam logic [4:0] OP_GT     = 5'd15;
   localparam logic [4:0] OP_GE     = 5'd16;

   // keywords packed first byte lowest, as the word buffer holds them
   localparam logic [47:0] KW_RETURN_TEXT = 48'h6E7275746572;
   localparam logic [47:0] KW_IF_TEXT     = 48'h000000006669;
   localparam logic [47:0] KW_ELSE_TEXT   = 48'h000065736C65;
   localparam logic [47:0] KW_WHILE_TEXT  = 48'h00656C696877;
   localparam logic [47:0] KW_FOR_TEXT    = 48'h000000726F66;
   localparam logic [7:0]  KW_RETURN_LEN  = 8'd6;
   localparam logic [7:0]  KW_IF_LEN      = 8'd2;
   localparam logic [7:0]  KW_ELSE_LEN    = 8'd4;
   localparam logic [7:0]  KW_WHILE_LEN   = 8'd5;
   localparam logic [7:0]  KW_FOR_LEN     = 8'd3;

   typedef struct packed {
      logic [3:0]  kind;
      logic [4:0]  op_code;
      logic [30:0] value;
      logic [15:0] start_res;
      logic [7:0]  length;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

@@ hdl/csl_channels.sv @@
interface csl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface csl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [4:0]  op_code;
   logic [30:0] value;
   logic [15:0] start_res;
   logic [7:0]  length;
   logic        last;

   modport source (output valid, output kind, output op_code, output value,
                   output start_res, output length, output last, input ready);
   modport sink (input valid, input kind, input op_code, input value,
                 input start_res, input length, input last, output ready);
endinterface

@@ hdl/c_subset_lexer.sv @@
// Streaming tokenizer for a small C subset.
// req_bus carries one source byte per transaction; byte 0 ends the text.
// rsp_bus carries one token per transaction: kind, op_code, value,
// start_res, length, and last, which marks the final token caused by a byte.
// Words, numbers and tokens that begin with <, >, = or ! are emitted when
// the byte after them arrives, other tokens with their own byte, so one
// byte causes zero, one or two tokens; the end byte flushes the pending
// token and then gives eof. A byte is captured in the input register and
// lexed from there into the result register, which drives rsp_bus.
// One byte is taken per cycle while each byte causes at most one token
// and rsp_bus is ready; a byte with two tokens holds the two-slot result
// register until its first token is taken.
// Reset clears the input register, the result register and the lexer
// state; the next byte starts a new text at offset 0.
// When the receiver stalls, the result register holds its tokens, the
// input register holds one byte, and req_bus.ready drops.
module c_subset_lexer #(
   parameter int POSITION_BITS = 16,
   parameter int NUMBER_BITS   = 31
) (
   input  logic    clock,
   input  logic    reset,
   csl_req_if.sink req_bus,
   csl_rsp_if.source rsp_bus
);
   import csl_pkg::*;

   logic                   in_valid_ff;
   logic [7:0]             in_ch_ff;
   mode_type               mode_ff;
   mode_type               mode_in;
   logic [47:0]            word_ff;
   logic [47:0]            word_in;
   logic [NUMBER_BITS-1:0] accum_ff;
   logic [NUMBER_BITS-1:0] accum_in;
   logic [POSITION_BITS-1:0] position_ff;
   logic [POSITION_BITS-1:0] position_in;
   logic [POSITION_BITS-1:0] token_start_ff;
   logic [POSITION_BITS-1:0] token_start_in;
   logic [7:0]             token_length_ff;
   logic [7:0]             token_length_in;
   result_pair_type        pair;
   logic                   can_load;
   logic                   advance;

   assign advance       = in_valid_ff && can_load;
   assign req_bus.ready = !in_valid_ff || can_load;

   // lex the held byte against the current state
   csl_step #(
      .POSITION_BITS (POSITION_BITS),
      .NUMBER_BITS   (NUMBER_BITS)
   ) u_step (
      .ch              (in_ch_ff),
      .mode            (mode_ff),
      .word_buffer     (word_ff),
      .number_accum    (accum_ff),
      .position        (position_ff),
      .token_start     (token_start_ff),
      .token_length    (token_length_ff),
      .mode_in         (mode_in),
      .word_buffer_in  (word_in),
      .number_accum_in (accum_in),
      .position_in     (position_in),
      .token_start_in  (token_start_in),
      .token_length_in (token_length_in),
      .pair            (pair)
   );

   // hold the tokens until the receiver takes them
   csl_result_buffer u_result_buffer (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .pair     (pair),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

   // track the input register and advance the lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         mode_ff         <= MODE_START;
         word_ff         <= '0;
         accum_ff        <= '0;
         position_ff     <= '0;
         token_start_ff  <= '0;
         token_length_ff <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff         <= mode_in;
            word_ff         <= word_in;
            accum_ff        <= accum_in;
            position_ff     <= position_in;
            token_start_ff  <= token_start_in;
            token_length_ff <= token_length_in;
         end
      end
   end

   // capture the byte of an accepted transaction
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_ch_ff <= req_bus.ch;
      end
   end

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_ch_ff == 8'h00 |=> position_ff == '0 && mode_ff == MODE_START)
      else $error("end of text did not clear the lexer state");

   a_word_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_WORD |-> token_length_ff != 8'd0)
      else $error("word pending with zero length");

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_load |=> in_valid_ff && $stable(in_ch_ff))
      else $error("held byte lost while the result register is full");
`endif

endmodule

@@ hdl/csl_step.sv @@
module csl_step #(
   parameter int POSITION_BITS = 16,
   parameter int NUMBER_BITS   = 31
) (
   input  logic [7:0]               ch,
   input  csl_pkg::mode_type        mode,
   input  logic [47:0]              word_buffer,
   input  logic [NUMBER_BITS-1:0]   number_accum,
   input  logic [POSITION_BITS-1:0] position,
   input  logic [POSITION_BITS-1:0] token_start,
   input  logic [7:0]               token_length,
   output csl_pkg::mode_type        mode_in,
   output logic [47:0]              word_buffer_in,
   output logic [NUMBER_BITS-1:0]   number_accum_in,
   output logic [POSITION_BITS-1:0] position_in,
   output logic [POSITION_BITS-1:0] token_start_in,
   output logic [7:0]               token_length_in,
   output csl_pkg::result_pair_type pair
);
   import csl_pkg::*;

   localparam int WideBits = NUMBER_BITS + 4;
   localparam logic [WideBits-1:0] NumMaxWide = {4'b0000, {NUMBER_BITS{1'b1}}};

   function automatic result_type make_res(input logic [3:0] kind, input logic [4:0] op,
                                           input logic [30:0] val,
                                           input logic [POSITION_BITS-1:0] start,
                                           input logic [7:0] len);
      result_type r;
      r.kind      = kind;
      r.op_code   = op;
      r.value     = val;
      r.start_res = 16'(start);
      r.length    = len;
      r.last      = 1'b0;
      return r;
   endfunction

   logic                   is_digit;
   logic                   is_word_char;
   logic                   is_end;
   logic [7:0]             length_bump;
   logic [47:0]            word_append;
   logic [WideBits-1:0]    accum_wide;
   logic [WideBits-1:0]    accum_sum;
   logic [NUMBER_BITS-1:0] accum_digit;
   logic [3:0]             word_kind;
   logic [4:0]             op_one;
   logic [4:0]             op_two;

   mode_type               b_mode;
   logic                   b_valid;
   result_type             b_res;
   logic [47:0]            b_word;
   logic [NUMBER_BITS-1:0] b_accum;

   logic                   pre_valid;
   result_type             pre_res;
   logic                   post_valid;
   result_type             post_res;
   logic                   use_begin;

   // classify the byte
   assign is_digit     = ch inside {["0":"9"]};
   assign is_word_char = ch inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
   assign is_end       = (ch == 8'h00);
   assign length_bump  = (token_length == 8'hFF) ? token_length : token_length + 8'd1;

   // append a byte to the word buffer while it holds fewer than six
   always_comb begin
      word_append = word_buffer;
      for (int i = 0; i < 6; i++) begin
         if (token_length == 8'(i)) begin
            word_append[8*i +: 8] = ch;
         end
      end
   end

   // multiply by ten and add the digit, saturate at the top value
   always_comb begin
      accum_wide = WideBits'(number_accum);
      accum_sum  = (accum_wide << 3) + (accum_wide << 1) + WideBits'(ch[3:0]);
      if (accum_sum > NumMaxWide) begin
         accum_digit = {NUMBER_BITS{1'b1}};
      end else begin
         accum_digit = accum_sum[NUMBER_BITS-1:0];
      end
   end

   // match the finished word against the keywords
   always_comb begin
      word_kind = KIND_IDENT;
      if (token_length == KW_RETURN_LEN && word_buffer == KW_RETURN_TEXT) begin
         word_kind = KIND_RETURN;
      end else if (token_length == KW_IF_LEN && word_buffer == KW_IF_TEXT) begin
         word_kind = KIND_IF;
      end else if (token_length == KW_ELSE_LEN && word_buffer == KW_ELSE_TEXT) begin
         word_kind = KIND_ELSE;
      end else if (token_length == KW_WHILE_LEN && word_buffer == KW_WHILE_TEXT) begin
         word_kind = KIND_WHILE;
      end else if (token_length == KW_FOR_LEN && word_buffer == KW_FOR_TEXT) begin
         word_kind = KIND_FOR;
      end
   end

   // pick the one- and two-character codes of a pending operator
   always_comb begin
      case (mode)
         MODE_LT: begin
            op_one = OP_LT;
            op_two = OP_LE;
         end
         MODE_GT: begin
            op_one = OP_GT;
            op_two = OP_GE;
         end
         default: begin
            op_one = OP_ASSIGN;
            op_two = OP_EQ;
         end
      endcase
   end

   // start a new token at this byte
   always_comb begin
      b_mode  = MODE_START;
      b_valid = 1'b0;
      b_res   = make_res(KIND_EOF, OP_NONE, 31'd0, position, 8'd1);
      b_word  = word_buffer;
      b_accum = number_accum;
      if (is_end) begin
         b_valid = 1'b1;
      end else if (ch inside {[8'h09:8'h0D], 8'h20}) begin
         b_mode = MODE_START;
      end else if (ch inside {["a":"z"]}) begin
         b_mode = MODE_WORD;
         b_word = {40'd0, ch};
      end else if (is_digit) begin
         b_mode  = MODE_NUM;
         b_accum = NUMBER_BITS'(ch[3:0]);
      end else begin
         case (ch)
            "<": b_mode = MODE_LT;
            ">": b_mode = MODE_GT;
            "=": b_mode = MODE_EQ;
            "!": b_mode = MODE_BANG;
            "+": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_PLUS, 31'd0, position, 8'd1);
            end
            "-": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_MINUS, 31'd0, position, 8'd1);
            end
            "*": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_STAR, 31'd0, position, 8'd1);
            end
            "/": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_SLASH, 31'd0, position, 8'd1);
            end
            "(": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_LPAREN, 31'd0, position, 8'd1);
            end
            ")": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_RPAREN, 31'd0, position, 8'd1);
            end
            ";": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_SEMI, 31'd0, position, 8'd1);
            end
            "{": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_LBRACE, 31'd0, position, 8'd1);
            end
            "}": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_RBRACE, 31'd0, position, 8'd1);
            end
            ",": begin
               b_valid = 1'b1;
               b_res   = make_res(KIND_OP, OP_COMMA, 31'd0, position, 8'd1);
            end
            default: begin
               b_valid = 1'b1;
               b_mode  = MODE_DROP;
               b_res   = make_res(KIND_ERROR, OP_NONE, 31'd0, position, 8'd1);
            end
         endcase
      end
   end

   // continue or close the pending token, then settle the next state
   always_comb begin
      mode_in         = mode;
      word_buffer_in  = word_buffer;
      number_accum_in = number_accum;
      token_start_in  = token_start;
      token_length_in = token_length;
      position_in     = position + POSITION_BITS'(1);
      pre_valid       = 1'b0;
      pre_res         = make_res(KIND_ERROR, OP_NONE, 31'd0, token_start, 8'd1);
      post_valid      = 1'b0;
      post_res        = b_res;
      use_begin       = 1'b0;

      case (mode)
         MODE_WORD: begin
            if (is_word_char) begin
               word_buffer_in  = word_append;
               token_length_in = length_bump;
            end else begin
               pre_valid = 1'b1;
               pre_res   = make_res(word_kind, OP_NONE, 31'd0, token_start, token_length);
               use_begin = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit) begin
               number_accum_in = accum_digit;
               token_length_in = length_bump;
            end else begin
               pre_valid = 1'b1;
               pre_res   = make_res(KIND_NUM, OP_NONE, 31'(number_accum), token_start,
                                    token_length);
               use_begin = 1'b1;
            end
         end
         MODE_LT, MODE_GT, MODE_EQ: begin
            pre_valid = 1'b1;
            if (ch == "=") begin
               pre_res = make_res(KIND_OP, op_two, 31'd0, token_start, 8'd2);
               mode_in = MODE_START;
            end else begin
               pre_res   = make_res(KIND_OP, op_one, 31'd0, token_start, 8'd1);
               use_begin = 1'b1;
            end
         end
         MODE_BANG: begin
            pre_valid = 1'b1;
            if (ch == "=") begin
               pre_res = make_res(KIND_OP, OP_NE, 31'd0, token_start, 8'd2);
               mode_in = MODE_START;
            end else begin
               // lone bang: error, and this byte is dropped unless it ends the text
               mode_in    = MODE_DROP;
               post_valid = is_end;
            end
         end
         MODE_DROP: begin
            post_valid = is_end;
         end
         default: begin
            use_begin = 1'b1;
         end
      endcase

      if (use_begin) begin
         mode_in         = b_mode;
         word_buffer_in  = b_word;
         number_accum_in = b_accum;
         token_start_in  = position;
         token_length_in = 8'd1;
         post_valid      = b_valid;
      end

      // end of text returns everything to the reset state
      if (is_end) begin
         mode_in         = MODE_START;
         word_buffer_in  = '0;
         number_accum_in = '0;
         position_in     = '0;
         token_start_in  = '0;
         token_length_in = '0;
      end
   end

   // order the results and mark the last one
   always_comb begin
      pair.second = post_res;
      if (pre_valid) begin
         pair.first = pre_res;
         pair.count = post_valid ? 2'd2 : 2'd1;
      end else begin
         pair.first = post_res;
         pair.count = post_valid ? 2'd1 : 2'd0;
      end
      pair.first.last  = (pair.count == 2'd1);
      pair.second.last = 1'b1;
   end

endmodule

@@ hdl/csl_result_buffer.sv @@
module csl_result_buffer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  csl_pkg::result_pair_type pair,
   output logic                     can_load,
   csl_rsp_if.source                rsp
);
   import csl_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   result_type slot0_ff;
   result_type slot0_in;
   result_type slot1_ff;
   result_type slot1_in;
   logic       pop;

   // drive the result channel from the head slot
   assign rsp.valid     = (count_ff != 2'd0);
   assign rsp.kind      = slot0_ff.kind;
   assign rsp.op_code   = slot0_ff.op_code;
   assign rsp.value     = slot0_ff.value;
   assign rsp.start_res = slot0_ff.start_res;
   assign rsp.length    = slot0_ff.length;
   assign rsp.last      = slot0_ff.last;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp.ready);

   // load a new pair when the slots are empty or the only token is taken, or advance the second slot
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = pair.count;
         slot0_in = pair.first;
         slot1_in = pair.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("last flag misplaced in a result pair");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd0 && slot0_ff.kind == KIND_EOF |-> slot0_ff.last)
      else $error("eof result not marked last");
`endif

endmodule
